[rtl/route_table_next_hop_engine_assert.svh]
// Assertion macros shared by the checker of the route table engine.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef ROUTE_TABLE_NEXT_HOP_ENGINE_ASSERT_SVH
`define ROUTE_TABLE_NEXT_HOP_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTNH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rtnh_pkg.sv]
// Package of the route table next-hop engine: operation codes, address
// constants, sequencer states and the table command group. No dependencies.
package rtnh_pkg;

    localparam int ADDR_W = 32;
    localparam int FUNC_W = 2;

    localparam logic [ADDR_W-1:0] ADDR_NONE = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0] ADDR_ZERO = 32'h0000_0000;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RSVD   = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Write-side commands to the table; they all share one write address.
    typedef struct packed {
        logic wr_dest;
        logic wr_hop;
        logic set_occ;
        logic clr_occ;
    } tbl_cmd_t;

endpackage

[rtl/rtnh_if.sv]
// Request and response channel interfaces of the route table engine.
// Depends on rtnh_pkg for the field widths.
interface rtnh_req_if
    import rtnh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] hop_addr;

    modport source (output valid, output func, output dest_addr, output hop_addr,
                    input ready);
    modport sink   (input valid, input func, input dest_addr, input hop_addr,
                    output ready);
endinterface

interface rtnh_rsp_if
    import rtnh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] next_hop;
    logic              status;

    modport source (output valid, output next_hop, output status, input ready);
    modport sink   (input valid, input next_hop, input status, output ready);
endinterface

[rtl/route_table_next_hop_engine.sv]
// Route table next-hop engine: a table of ENTRIES destination/next-hop pairs
// with lookup, add-or-update and delete-by-next-hop operations, one request
// beat in and one response beat out per operation. A lookup of the broadcast
// address and the unused operation code are answered without touching the
// table: the sequencer goes straight from idle to done, and the result is
// loaded into the response register once that is free. Every other
// operation scans the table through its single read port, one entry per
// cycle (lookups and updates that hit stop the scan early). The engine
// holds one operation at a time and raises req.ready again once the result
// sits in the response register, so a new request overlaps a waiting
// response. Reset empties the table at once; there is no clearing pass.
// Depends on rtnh_pkg, rtnh_if and rtnh_table.
module route_table_next_hop_engine
    import rtnh_pkg::*;
#(
    parameter int ENTRIES = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    rtnh_req_if.sink   req,
    rtnh_rsp_if.source rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

    // Sequencer state and the operation being served.
    state_t            state_reg, state_next;
    logic [FUNC_W-1:0] op_reg;
    logic [ADDR_W-1:0] dest_reg;
    logic [ADDR_W-1:0] hop_reg;

    // Scan pipeline: rd_cnt_reg is the next entry to read, cmp_idx_reg the
    // entry whose words sit in the table's read register this cycle.
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              free_vld_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // Result under construction and the response register.
    logic [ADDR_W-1:0] res_hop_reg;
    logic              res_status_reg;
    logic              rsp_valid_reg;
    logic [ADDR_W-1:0] rsp_hop_reg;
    logic              rsp_status_reg;

    // Table interface.
    logic              tbl_rd_en;
    tbl_cmd_t          tbl_cmd;
    logic [IDX_W-1:0]  tbl_wr_addr;
    logic [ADDR_W-1:0] tbl_rd_dest;
    logic [ADDR_W-1:0] tbl_rd_hop;
    logic              tbl_rd_occ;

    logic              req_direct;
    logic              issue;
    logic [ADDR_W-1:0] cmp_data;
    logic [ADDR_W-1:0] cmp_key;
    logic              hit;
    logic              scan_end;
    logic              finish;
    logic              rsp_free;

    rtnh_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (tbl_rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .cmd     (tbl_cmd),
        .wr_addr (tbl_wr_addr),
        .wr_dest (dest_reg),
        .wr_hop  (hop_reg),
        .rd_dest (tbl_rd_dest),
        .rd_hop  (tbl_rd_hop),
        .rd_occ  (tbl_rd_occ)
    );

    // Broadcast lookups and the unused code need no scan.
    assign req_direct = (req.func == FUNC_RSVD) ||
                        ((req.func == FUNC_LOOKUP) && (req.dest_addr == ADDR_NONE));

    assign issue = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_END);

    // The one shared comparator: deletes match on the next-hop word,
    // lookups and adds on the destination word. Empty entries never match.
    assign cmp_data = (op_reg == FUNC_DEL) ? tbl_rd_hop : tbl_rd_dest;
    assign cmp_key  = (op_reg == FUNC_DEL) ? hop_reg : dest_reg;
    assign hit      = (state_reg == ST_SCAN) && cmp_vld_reg && tbl_rd_occ &&
                      (cmp_data == cmp_key);

    // The scan is over when nothing is left to read and nothing is in flight.
    assign scan_end = (state_reg == ST_SCAN) && !cmp_vld_reg && !issue;
    assign finish   = scan_end || (hit && (op_reg != FUNC_DEL));
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = req_direct ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table commands. An update that hits rewrites the next hop in place; a
    // delete clears occupancy of each hit; an add that missed fills the first
    // free entry once the scan is over. An add of the broadcast address
    // stores its next hop but leaves the entry empty.
    always_comb
    begin
        tbl_rd_en   = issue;
        tbl_cmd     = '0;
        tbl_wr_addr = cmp_idx_reg;
        if (hit && (op_reg == FUNC_ADD))
        begin
            tbl_cmd.wr_hop = 1'b1;
        end
        if (hit && (op_reg == FUNC_DEL))
        begin
            tbl_cmd.clr_occ = 1'b1;
        end
        if (scan_end && (op_reg == FUNC_ADD) && free_vld_reg)
        begin
            tbl_wr_addr     = free_idx_reg;
            tbl_cmd.wr_dest = 1'b1;
            tbl_cmd.wr_hop  = 1'b1;
            tbl_cmd.set_occ = (dest_reg != ADDR_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            free_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_IDLE) && req.valid)
            begin
                rd_cnt_reg   <= '0;
                cmp_vld_reg  <= 1'b0;
                free_vld_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                cmp_vld_reg <= issue && !finish;
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg && !tbl_rd_occ && !free_vld_reg)
                begin
                    free_vld_reg <= 1'b1;
                end
            end
            if ((state_reg == ST_DONE) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && req.valid)
        begin
            op_reg         <= req.func;
            dest_reg       <= req.dest_addr;
            hop_reg        <= req.hop_addr;
            // A lookup defaults to a miss; every other operation reports zero.
            res_hop_reg    <= (req.func == FUNC_LOOKUP) ? ADDR_NONE : ADDR_ZERO;
            res_status_reg <= STATUS_OK;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (issue)
            begin
                cmp_idx_reg <= rd_cnt_reg[IDX_W-1:0];
            end
            if (cmp_vld_reg && !tbl_rd_occ && !free_vld_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
            if (hit && (op_reg == FUNC_LOOKUP))
            begin
                res_hop_reg <= tbl_rd_hop;
            end
            if (scan_end && (op_reg == FUNC_ADD) && !free_vld_reg)
            begin
                res_status_reg <= STATUS_FULL;
            end
        end
        if ((state_reg == ST_DONE) && rsp_free)
        begin
            rsp_hop_reg    <= res_hop_reg;
            rsp_status_reg <= res_status_reg;
        end
    end

    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.next_hop = rsp_hop_reg;
    assign rsp.status   = rsp_status_reg;

endmodule

[rtl/rtnh_table.sv]
// Route table storage: destination and next-hop memories plus occupancy flags.
// Depends on rtnh_pkg for the command struct and address width.
module rtnh_table
    import rtnh_pkg::*;
#(
    parameter int ENTRIES = 32,
    parameter int IDX_W   = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    input  tbl_cmd_t          cmd,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [ADDR_W-1:0] wr_dest,
    input  logic [ADDR_W-1:0] wr_hop,
    output logic [ADDR_W-1:0] rd_dest,
    output logic [ADDR_W-1:0] rd_hop,
    output logic              rd_occ
);

    logic [ADDR_W-1:0] dest_mem [ENTRIES];
    logic [ADDR_W-1:0] hop_mem  [ENTRIES];
    logic [ENTRIES-1:0] occ_reg;
    logic [ADDR_W-1:0] rd_dest_reg;
    logic [ADDR_W-1:0] rd_hop_reg;
    logic              rd_occ_reg;

    // An entry is occupied only while it holds a real destination, so the
    // memories need no reset: unoccupied words are never compared.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_dest)
        begin
            dest_mem[wr_addr] <= wr_dest;
        end
        if (cmd.wr_hop)
        begin
            hop_mem[wr_addr] <= wr_hop;
        end
        if (rd_en)
        begin
            rd_dest_reg <= dest_mem[rd_addr];
            rd_hop_reg  <= hop_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            rd_occ_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_occ)
            begin
                occ_reg[wr_addr] <= 1'b1;
            end
            else if (cmd.clr_occ)
            begin
                occ_reg[wr_addr] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_occ_reg <= occ_reg[rd_addr];
            end
        end
    end

    assign rd_dest = rd_dest_reg;
    assign rd_hop  = rd_hop_reg;
    assign rd_occ  = rd_occ_reg;

endmodule

[rtl/rtnh_chk.sv]
// Port-level checker for the route table engine, bound to the top level.
// Depends on rtnh_pkg and the assertion macro header.
`include "route_table_next_hop_engine_assert.svh"

module rtnh_chk
    import rtnh_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [ADDR_W-1:0] next_hop,
    input logic              status
);

    // A stalled response beat keeps its payload.
    `RTNH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(next_hop) && $stable(status), "response changed while stalled")

    // Only one operation is served at a time.
    `RTNH_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

    // A full report belongs to an add, whose next hop is zero.
    `RTNH_ASSERT_SAME(a_full_zero_hop, rsp_valid && status, next_hop == ADDR_ZERO, "full status with nonzero next hop")

endmodule

bind route_table_next_hop_engine rtnh_chk u_rtnh_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .next_hop  (rsp.next_hop),
    .status    (rsp.status)
);
